@@ rtl/tdp_pkg.sv @@
// types, microcode encoding and control store for the trial division prime test
`timescale 1ns / 1ps
`default_nettype none
package tdp_pkg;

	// width of the microcode step counter
	localparam int UPC_W = 4;

	// datapath operations
	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_INIT_D,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_NEXT_D,
		OP_WRITE0,
		OP_WRITE1
	} op_t;

	// jump conditions
	typedef enum logic [3:0] {
		CND_NEVER,
		CND_ALWAYS,
		CND_NO_REQ,
		CND_N_LT2,
		CND_N_EQ2,
		CND_N_EVEN,
		CND_SQ_GT_N,
		CND_CNT_NZ,
		CND_REM_ZERO,
		CND_OUT_BUSY
	} cond_t;

	// one control word
	typedef struct packed {
		op_t              op;
		cond_t            cond;
		logic [UPC_W-1:0] target;
	} ctrl_word_t;

	// status flags from the datapath
	typedef struct packed {
		logic no_req;
		logic n_lt2;
		logic n_eq2;
		logic n_even;
		logic sq_gt_n;
		logic cnt_nz;
		logic rem_zero;
		logic out_busy;
	} flags_t;

	// step addresses
	localparam logic [UPC_W-1:0] STEP_IDLE     = 4'd0;
	localparam logic [UPC_W-1:0] STEP_LT2      = 4'd1;
	localparam logic [UPC_W-1:0] STEP_EQ2      = 4'd2;
	localparam logic [UPC_W-1:0] STEP_EVEN     = 4'd3;
	localparam logic [UPC_W-1:0] STEP_INIT     = 4'd4;
	localparam logic [UPC_W-1:0] STEP_BOUND    = 4'd5;
	localparam logic [UPC_W-1:0] STEP_DIV_INIT = 4'd6;
	localparam logic [UPC_W-1:0] STEP_DIV      = 4'd7;
	localparam logic [UPC_W-1:0] STEP_REM      = 4'd8;
	localparam logic [UPC_W-1:0] STEP_NEXT     = 4'd9;
	localparam logic [UPC_W-1:0] STEP_R0       = 4'd10;
	localparam logic [UPC_W-1:0] STEP_R0_DONE  = 4'd11;
	localparam logic [UPC_W-1:0] STEP_R1       = 4'd12;
	localparam logic [UPC_W-1:0] STEP_R1_DONE  = 4'd13;

	// control store: jump to target when the condition holds, else next step
	function automatic ctrl_word_t micro_rom(input logic [UPC_W-1:0] addr);
		ctrl_word_t w;
		begin
			case (addr)
				STEP_IDLE:     w = '{OP_LOAD,     CND_NO_REQ,   STEP_IDLE};
				STEP_LT2:      w = '{OP_NOP,      CND_N_LT2,    STEP_R0};
				STEP_EQ2:      w = '{OP_NOP,      CND_N_EQ2,    STEP_R1};
				STEP_EVEN:     w = '{OP_NOP,      CND_N_EVEN,   STEP_R0};
				STEP_INIT:     w = '{OP_INIT_D,   CND_NEVER,    STEP_IDLE};
				STEP_BOUND:    w = '{OP_NOP,      CND_SQ_GT_N,  STEP_R1};
				STEP_DIV_INIT: w = '{OP_DIV_INIT, CND_NEVER,    STEP_IDLE};
				STEP_DIV:      w = '{OP_DIV_STEP, CND_CNT_NZ,   STEP_DIV};
				STEP_REM:      w = '{OP_NOP,      CND_REM_ZERO, STEP_R0};
				STEP_NEXT:     w = '{OP_NEXT_D,   CND_ALWAYS,   STEP_BOUND};
				STEP_R0:       w = '{OP_WRITE0,   CND_OUT_BUSY, STEP_R0};
				STEP_R0_DONE:  w = '{OP_NOP,      CND_ALWAYS,   STEP_IDLE};
				STEP_R1:       w = '{OP_WRITE1,   CND_OUT_BUSY, STEP_R1};
				STEP_R1_DONE:  w = '{OP_NOP,      CND_ALWAYS,   STEP_IDLE};
				default:       w = '{OP_NOP,      CND_ALWAYS,   STEP_IDLE};
			endcase
			return w;
		end
	endfunction

endpackage
`default_nettype wire

@@ rtl/tdp_if.sv @@
// request and result channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface tdp_req_if #(
	parameter int VALUE_BITS = 31
);
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] candidate;

	modport source (output valid, output candidate, input ready);
	modport sink   (input valid, input candidate, output ready);
endinterface

interface tdp_res_if;
	logic valid;
	logic ready;
	logic is_prime;

	modport source (output valid, output is_prime, input ready);
	modport sink   (input valid, input is_prime, output ready);
endinterface
`default_nettype wire

@@ rtl/tdp_sequencer.sv @@
// microcode step counter, control store lookup and conditional jumps
`timescale 1ns / 1ps
`default_nettype none
module tdp_sequencer
	import tdp_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire flags_t flags,
	output ctrl_word_t ctrl
);

	logic [UPC_W-1:0] upc_q;
	logic             take;

	// current control word
	assign ctrl = micro_rom(upc_q);

	// condition select
	always_comb begin
		case (ctrl.cond)
			CND_NEVER:    take = 1'b0;
			CND_ALWAYS:   take = 1'b1;
			CND_NO_REQ:   take = flags.no_req;
			CND_N_LT2:    take = flags.n_lt2;
			CND_N_EQ2:    take = flags.n_eq2;
			CND_N_EVEN:   take = flags.n_even;
			CND_SQ_GT_N:  take = flags.sq_gt_n;
			CND_CNT_NZ:   take = flags.cnt_nz;
			CND_REM_ZERO: take = flags.rem_zero;
			CND_OUT_BUSY: take = flags.out_busy;
			default:      take = 1'b1;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= STEP_IDLE;
		end else if (take) begin
			upc_q <= ctrl.target;
		end else begin
			upc_q <= upc_q + 1'b1;
		end
	end

endmodule
`default_nettype wire

@@ rtl/tdp_datapath.sv @@
// candidate, divisor, square and remainder registers with the result register
`timescale 1ns / 1ps
`default_nettype none
module tdp_datapath
	import tdp_pkg::*;
#(
	parameter int VALUE_BITS = 31
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire ctrl_word_t ctrl,
	output flags_t     flags,
	tdp_req_if.sink    req,
	tdp_res_if.source  res
);

	// divisor width covers the square root bound plus one odd step past it
	localparam int D_W   = (VALUE_BITS + 1) / 2 + 1;
	localparam int SQ_W  = 2 * D_W;
	localparam int CNT_W = $clog2(VALUE_BITS);
	localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(VALUE_BITS - 1);

	logic [VALUE_BITS-1:0] n_q;
	logic [D_W-1:0]        d_q;
	logic [SQ_W-1:0]       sq_q;
	logic [D_W-1:0]        rem_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  out_valid_q;
	logic                  is_prime_q;

	logic [D_W:0]          rem_sh;
	logic [D_W:0]          rem_sub;
	logic                  rem_ge;
	logic                  write_en;

	// shift-subtract remainder step, one candidate bit per cycle
	assign rem_sh  = {rem_q, n_q[cnt_q]};
	assign rem_ge  = rem_sh >= {1'b0, d_q};
	assign rem_sub = rem_sh - {1'b0, d_q};

	// handshake
	assign req.ready    = (ctrl.op == OP_LOAD);
	assign res.valid    = out_valid_q;
	assign res.is_prime = is_prime_q;

	// status flags
	always_comb begin
		flags.no_req   = !req.valid;
		flags.n_lt2    = (n_q < VALUE_BITS'(2));
		flags.n_eq2    = (n_q == VALUE_BITS'(2));
		flags.n_even   = !n_q[0];
		flags.sq_gt_n  = (sq_q > SQ_W'(n_q));
		flags.cnt_nz   = (cnt_q != '0);
		flags.rem_zero = (rem_q == '0);
		flags.out_busy = out_valid_q && !res.ready;
	end

	assign write_en = ((ctrl.op == OP_WRITE0) || (ctrl.op == OP_WRITE1)) && !flags.out_busy;

	// working registers
	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_LOAD: begin
				if (req.valid) begin
					n_q <= req.candidate;
				end
			end
			OP_INIT_D: begin
				d_q  <= D_W'(3);
				sq_q <= SQ_W'(9);
			end
			OP_DIV_INIT: begin
				rem_q <= '0;
				cnt_q <= CNT_TOP;
			end
			OP_DIV_STEP: begin
				rem_q <= rem_ge ? rem_sub[D_W-1:0] : rem_sh[D_W-1:0];
				cnt_q <= cnt_q - 1'b1;
			end
			OP_NEXT_D: begin
				// (d + 2)^2 = d^2 + 4d + 4
				d_q  <= d_q + D_W'(2);
				sq_q <= sq_q + SQ_W'({d_q, 2'b00}) + SQ_W'(4);
			end
			default: begin
			end
		endcase
		if (write_en) begin
			is_prime_q <= (ctrl.op == OP_WRITE1);
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (write_en) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef ASSERT_OFF
	// remainder stays below the divisor through every division step
	assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_DIV_STEP) |=> (rem_q < d_q))
		else $error("remainder not below divisor");

	// trial divisors are always odd
	assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_NEXT_D) |=> d_q[0])
		else $error("even trial divisor");

	// a prime verdict never goes out for an even candidate other than two
	assert property (@(posedge clk) disable iff (!arst_n)
		(write_en && (ctrl.op == OP_WRITE1)) |-> (n_q[0] || n_q == VALUE_BITS'(2)))
		else $error("even candidate reported prime");

	// a result written while the slot is held would overwrite it
	assert property (@(posedge clk) disable iff (!arst_n)
		write_en |-> (!out_valid_q || res.ready))
		else $error("result slot overwritten");
`endif

endmodule
`default_nettype wire

@@ rtl/trial_division_prime_test.sv @@
// Trial division prime test: one candidate in, one verdict out.
// Verdicts for 0, 1, 2 and even values come from the flag checks alone; otherwise
// one bit-serial remainder pass per odd trial divisor, up to sqrt(candidate) / 2 divisors.
// One candidate at a time: a new one is taken only in the idle step, after the verdict is written.
// Reset (arst_n, asynchronous, active low) clears the step counter and result valid.
`timescale 1ns / 1ps
`default_nettype none
module trial_division_prime_test
	import tdp_pkg::*;
#(
	parameter int VALUE_BITS = 31
) (
	input  wire       clk,
	input  wire       arst_n,
	tdp_req_if.sink   req,
	tdp_res_if.source res
);

	ctrl_word_t ctrl;
	flags_t     flags;

	// microcode control
	tdp_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	// datapath
	tdp_datapath #(
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.flags  (flags),
		.req    (req),
		.res    (res)
	);

endmodule
`default_nettype wire
